// ===== sv/apes_pkg.sv =====
// Shared widths, status types and magnitude helpers for the product-except-self block.
`timescale 1ns / 1ps
package apes_pkg;

  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 64;

  // Status from the multiply and overflow-check unit
  typedef struct packed {
    logic done;
    logic ovf;
  } acc_status_t;

  // Magnitude of a 64-bit two's complement pattern (-2^63 gives 2^63 unsigned)
  function automatic logic [RESULT_W-1:0] mag64(input logic [RESULT_W-1:0] x);
    mag64 = x[RESULT_W-1] ? (~x + RESULT_W'(1)) : x;
  endfunction

  // Magnitude of a 32-bit two's complement pattern (-2^31 gives 2^31 unsigned)
  function automatic logic [VALUE_W-1:0] mag32(input logic [VALUE_W-1:0] x);
    mag32 = x[VALUE_W-1] ? (~x + VALUE_W'(1)) : x;
  endfunction

endpackage

// ===== sv/apes_store.sv =====
// Element memory: one write port, one registered read port.
`timescale 1ns / 1ps
module apes_store
  import apes_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/apes_acc.sv =====
// Running-product update: 64x32 multiply in two partial products, then range check.
`timescale 1ns / 1ps
module apes_acc
  import apes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RESULT_W-1:0] product,
  input  logic [VALUE_W-1:0]  value,
  output acc_status_t         status,
  output logic [RESULT_W-1:0] product_next
);

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_CHK} phase_t;

  phase_t               phase;
  logic [RESULT_W-1:0]  pm;
  logic [VALUE_W-1:0]   vm;
  logic                 rn;
  logic [RESULT_W-1:0]  pl;
  logic [RESULT_W-1:0]  ph;
  logic [VALUE_W-1:0]   mul_a;
  logic [RESULT_W-1:0]  mul_p;
  logic [RESULT_W:0]    upper;
  logic [RESULT_W-1:0]  mag;
  logic [RESULT_W-1:0]  limit;
  logic                 too_big;

  assign mul_a = (phase == PH_LO) ? pm[VALUE_W-1:0] : pm[RESULT_W-1:VALUE_W];
  assign mul_p = {{VALUE_W{1'b0}}, mul_a} * {{VALUE_W{1'b0}}, vm};

  // Full product is {upper, pl[31:0]}; anything above bit 63 is out of range
  assign upper   = {1'b0, ph} + {{(VALUE_W+1){1'b0}}, pl[RESULT_W-1:VALUE_W]};
  assign mag     = {upper[VALUE_W-1:0], pl[VALUE_W-1:0]};
  assign limit   = rn ? {1'b1, {(RESULT_W-1){1'b0}}} : {1'b0, {(RESULT_W-1){1'b1}}};
  assign too_big = (upper[RESULT_W:VALUE_W] != '0) || (mag > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      status.done <= 1'b0;
      status.ovf  <= 1'b0;
    end else begin
      status.done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            pm    <= mag64(product);
            vm    <= mag32(value);
            rn    <= product[RESULT_W-1] ^ value[VALUE_W-1];
            phase <= PH_LO;
          end
        end
        PH_LO: begin
          pl    <= mul_p;
          phase <= PH_HI;
        end
        PH_HI: begin
          ph    <= mul_p;
          phase <= PH_CHK;
        end
        PH_CHK: begin
          status.done  <= 1'b1;
          status.ovf   <= too_big;
          product_next <= rn ? (~mag + RESULT_W'(1)) : mag;
          phase        <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/apes_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module apes_div
  import apes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RESULT_W-1:0] dividend,
  input  logic [VALUE_W-1:0]  divisor,
  output logic                done,
  output logic [RESULT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(RESULT_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] dvs;
  logic [VALUE_W:0]   shifted;
  logic [VALUE_W:0]   diff;
  logic               fits;

  assign shifted = {rem, quotient[RESULT_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        cnt      <= CNT_W'(RESULT_W - 1);
      end else if (busy) begin
        // dividend bits shift out at the top while quotient bits enter below
        rem      <= fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
        quotient <= {quotient[RESULT_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== sv/array_product_except_self.sv =====
// Top level: load an array, then emit the product of all other elements for each.
//
// Input channel s_*: one signed 32-bit element per transaction on s_tdata,
// s_tlast marks the final element. The array may hold up to MAX_ELEMENTS
// elements; the MAX_ELEMENTS-th element ends the array even without s_tlast.
// Output channel m_*: one result per element, in order. m_tdata carries the
// signed 64-bit product of the other elements, m_tuser[0] flags overflow
// (m_tdata is then zero), m_tlast marks the result for the final element.
//
// Loading: a zero element, or any element once overflow is seen, is stored
// without a multiply; a nonzero element also takes two partial products
// through the shared 32x32 multiplier, then the range check. Emission: each
// result is read back from the element memory and offered on m_*, passing
// first through the bit-serial 64/32 divider when no zero and no overflow
// is present. Loading and emission do not overlap: s_tready is low from the
// final element until the last result is taken. A stalled m_tready holds the
// result steady. After rst the block is empty and ready to load; the element
// memory is not cleared, as only entries of the current array are read.
`timescale 1ns / 1ps
module array_product_except_self
  import apes_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [VALUE_W-1:0]  s_tdata,   // value[31:0]
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata,   // product_except[63:0]
  output logic [0:0]          m_tuser,   // overflow[0]
  output logic                m_tlast
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {S_LOAD, S_ACC, S_RD, S_RES, S_DIV, S_OUT} state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       k;
  logic [RESULT_W-1:0] running_product;
  logic [1:0]          zero_count;
  logic [AW-1:0]       first_zero_pos;
  logic                ovf_seen;
  logic                final_pend;
  logic                rn;

  logic                in_accept;
  logic                out_accept;
  logic                last_eff;
  logic                acc_start;
  logic                div_start;
  acc_status_t         acc_st;
  logic [RESULT_W-1:0] acc_product;
  logic [VALUE_W-1:0]  rd_data;
  logic                div_done;
  logic [RESULT_W-1:0] quotient;

  assign s_tready   = (state == S_LOAD);
  assign m_tvalid   = (state == S_OUT);
  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign last_eff   = s_tlast || (count == CW'(MAX_ELEMENTS - 1));
  assign acc_start  = in_accept && (s_tdata != '0) && !ovf_seen;
  assign div_start  = (state == S_RES) && !ovf_seen && (zero_count == 2'd0);

  apes_store #(
    .DEPTH(MAX_ELEMENTS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (in_accept),
    .waddr(count[AW-1:0]),
    .wdata(s_tdata),
    .raddr(k[AW-1:0]),
    .rdata(rd_data)
  );

  apes_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .start       (acc_start),
    .product     (running_product),
    .value       (s_tdata),
    .status      (acc_st),
    .product_next(acc_product)
  );

  apes_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mag64(running_product)),
    .divisor (mag32(rd_data)),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      count           <= '0;
      k               <= '0;
      running_product <= RESULT_W'(1);
      zero_count      <= 2'd0;
      first_zero_pos  <= '0;
      ovf_seen        <= 1'b0;
      final_pend      <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_accept) begin
            count <= count + CW'(1);
            if (s_tdata == '0) begin
              if (zero_count == 2'd0) begin
                first_zero_pos <= count[AW-1:0];
              end
              if (zero_count != 2'd2) begin
                zero_count <= zero_count + 2'd1;
              end
            end
            if (acc_start) begin
              final_pend <= last_eff;
              state      <= S_ACC;
            end else if (last_eff) begin
              k     <= '0;
              state <= S_RD;
            end
          end
        end
        S_ACC: begin
          if (acc_st.done) begin
            if (acc_st.ovf) begin
              ovf_seen <= 1'b1;
            end else begin
              running_product <= acc_product;
            end
            if (final_pend) begin
              k     <= '0;
              state <= S_RD;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_RD: begin
          // read address is k; data arrives next cycle
          state <= S_RES;
        end
        S_RES: begin
          m_tlast <= (k + CW'(1) == count);
          if (ovf_seen) begin
            m_tdata <= '0;
            m_tuser <= 1'b1;
            state   <= S_OUT;
          end else if (zero_count == 2'd2) begin
            m_tdata <= '0;
            m_tuser <= 1'b0;
            state   <= S_OUT;
          end else if (zero_count == 2'd1) begin
            m_tdata <= (k[AW-1:0] == first_zero_pos) ? running_product : '0;
            m_tuser <= 1'b0;
            state   <= S_OUT;
          end else begin
            rn    <= running_product[RESULT_W-1] ^ rd_data[VALUE_W-1];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // a positive quotient of 2^63 does not fit
            if (!rn && quotient[RESULT_W-1]) begin
              m_tdata <= '0;
              m_tuser <= 1'b1;
            end else begin
              m_tdata <= rn ? (~quotient + RESULT_W'(1)) : quotient;
              m_tuser <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_accept) begin
            if (m_tlast) begin
              count           <= '0;
              running_product <= RESULT_W'(1);
              zero_count      <= 2'd0;
              first_zero_pos  <= '0;
              ovf_seen        <= 1'b0;
              state           <= S_LOAD;
            end else begin
              k     <= k + CW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== sv/apes_checker.sv =====
// Port-level checks for the product-except-self block, bound to the top level.
`timescale 1ns / 1ps
module apes_checker
  import apes_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [RESULT_W-1:0] m_tdata,
  input logic [0:0]          m_tuser,
  input logic                m_tlast
);

  // A result waiting on the receiver holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Loading and emitting never overlap
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is offered");

  // An overflow result carries zero
  a_ovf_zero: assert property (@(posedge clk) m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("overflow result with nonzero data");

  // Reset leaves the block empty and ready to load
  a_reset: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // After the final result is taken the block loads again
  a_reload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("input not ready after the final result");

endmodule

bind array_product_except_self apes_checker u_apes_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ===== bench/tb_array_product_except_self.sv =====
// Testbench for array_product_except_self: directed table, then checked random arrays.
`timescale 1ns / 1ps
module tb_array_product_except_self;
  import apes_pkg::*;

  localparam int DEPTH        = 64;
  localparam int PHASE_ITEMS  = 95;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_ROWS       = 23;

  localparam logic [VALUE_W-1:0]  MIN32 = 32'h8000_0000;
  localparam logic [VALUE_W-1:0]  MAX32 = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0]  NEG1  = 32'hFFFF_FFFF;
  localparam logic [RESULT_W-1:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [RESULT_W-1:0] MIN64 = 64'h8000_0000_0000_0000;

  localparam int SRC_IDLE   [4] = '{0, 79, 0, 7};
  localparam int SINK_STALL [4] = '{0, 0, 79, 7};

  typedef struct packed {
    logic [RESULT_W-1:0] product;
    logic                ovf;
    logic                last;
  } product_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic                known;    // expected result typed in below
    logic [RESULT_W-1:0] product;
    logic                ovf;
  } row_t;

  localparam row_t DIRECTED [N_ROWS] = '{
    // single element: product of nothing
    '{32'd5, 1'b1, 1'b1, 64'd1, 1'b0},
    // a lone zero takes the empty product
    '{32'd0, 1'b1, 1'b1, 64'd1, 1'b0},
    // two zeros
    '{32'd0, 1'b0, 1'b1, 64'd0, 1'b0},
    '{32'd0, 1'b1, 1'b1, 64'd0, 1'b0},
    // one zero in the middle
    '{32'd3, 1'b0, 1'b1, 64'd0, 1'b0},
    '{32'd0, 1'b0, 1'b1, 64'd21, 1'b0},
    '{32'd7, 1'b1, 1'b1, 64'd0, 1'b0},
    // extremes of the positive range and minus one
    '{MAX32, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{NEG1,  1'b1, 1'b1, 64'h0000_0000_7FFF_FFFF, 1'b0},
    // most negative element squared
    '{MIN32, 1'b0, 1'b0, '0, 1'b0},
    '{MIN32, 1'b1, 1'b0, '0, 1'b0},
    // running product overflow
    '{MIN32, 1'b0, 1'b1, 64'd0, 1'b1},
    '{MIN32, 1'b0, 1'b1, 64'd0, 1'b1},
    '{MIN32, 1'b1, 1'b1, 64'd0, 1'b1},
    // overflow wins over a zero
    '{MIN32, 1'b0, 1'b1, 64'd0, 1'b1},
    '{MIN32, 1'b0, 1'b1, 64'd0, 1'b1},
    '{MIN32, 1'b0, 1'b1, 64'd0, 1'b1},
    '{32'd0, 1'b1, 1'b1, 64'd0, 1'b1},
    // product of exactly -2^63; dividing by minus one leaves the range
    '{MIN32, 1'b0, 1'b0, '0, 1'b0},
    '{MIN32, 1'b0, 1'b0, '0, 1'b0},
    '{NEG1,  1'b0, 1'b1, 64'd0, 1'b1},
    '{32'd2, 1'b1, 1'b0, '0, 1'b0},
    '{32'd1, 1'b1, 1'b1, 64'd1, 1'b0}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [VALUE_W-1:0]  s_tdata  = '0;    // value[31:0]
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;          // product_except[63:0]
  logic [0:0]          m_tuser;          // overflow[0]
  logic                m_tlast;

  array_product_except_self #(.MAX_ELEMENTS(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the array being loaded
  logic [VALUE_W-1:0]  held_values [DEPTH];
  int                  held_count;
  logic [RESULT_W-1:0] nz_product;
  int                  zeros;
  int                  first_zero;
  logic                product_ovf;
  logic                known_valid   [DEPTH];
  logic [RESULT_W-1:0] known_product [DEPTH];
  logic                known_ovf     [DEPTH];
  product_t            pending_products [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int errors         = 0;
  int cycles         = 0;
  int n_arrays       = 0;
  int n_elements     = 0;
  int n_results      = 0;
  int n_ovf_results  = 0;

  function automatic void clear_array();
    held_count  = 0;
    nz_product  = 64'd1;
    zeros       = 0;
    first_zero  = 0;
    product_ovf = 1'b0;
    for (int k = 0; k < DEPTH; k++) known_valid[k] = 1'b0;
  endfunction

  function automatic void emit_products();
    product_t            r;
    logic [RESULT_W-1:0] pm;
    logic [RESULT_W-1:0] em;
    logic [RESULT_W-1:0] q;
    logic                neg;
    pm = nz_product[RESULT_W-1] ? 64'd0 - nz_product : nz_product;
    for (int k = 0; k < held_count; k++) begin
      r = '0;
      r.last = (k == held_count - 1);
      if (product_ovf) begin
        r.ovf = 1'b1;
      end else if (zeros == 1) begin
        r.product = (k == first_zero) ? nz_product : '0;
      end else if (zeros == 0) begin
        em  = held_values[k][VALUE_W-1] ? 64'h1_0000_0000 - {32'd0, held_values[k]}
                                        : {32'd0, held_values[k]};
        neg = nz_product[RESULT_W-1] ^ held_values[k][VALUE_W-1];
        q   = pm / em;
        // +2^63 cannot be represented
        if (!neg && q > MAX64) r.ovf = 1'b1;
        else r.product = neg ? 64'd0 - q : q;
      end
      if (known_valid[k]) begin
        r.product = known_product[k];
        r.ovf     = known_ovf[k];
      end
      pending_products.push_back(r);
    end
    n_arrays++;
    clear_array();
  endfunction

  function automatic void fold_element(input logic [VALUE_W-1:0] v, input logic l);
    logic [RESULT_W-1:0] pm;
    logic [RESULT_W-1:0] vm;
    logic [RESULT_W-1:0] lim;
    logic [RESULT_W-1:0] m;
    logic                neg;
    held_values[held_count] = v;
    if (v == '0) begin
      if (zeros == 0) first_zero = held_count;
      if (zeros < 2) zeros++;
    end else if (!product_ovf) begin
      pm  = nz_product[RESULT_W-1] ? 64'd0 - nz_product : nz_product;
      vm  = v[VALUE_W-1] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
      neg = nz_product[RESULT_W-1] ^ v[VALUE_W-1];
      lim = neg ? MIN64 : MAX64;
      // freeze the product once it leaves the signed range
      if (pm > lim / vm) begin
        product_ovf = 1'b1;
      end else begin
        m          = pm * vm;
        nz_product = neg ? 64'd0 - m : m;
      end
    end
    held_count++;
    n_elements++;
    if (l || held_count == DEPTH) emit_products();
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value(input bit tame);
    int unsigned        r;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (tame) begin
      if (r < 4) v = '0;
      else if (r < 50) v = r[0] ? NEG1 : 32'd1;
      else v = VALUE_W'($urandom_range(6)) - 32'd3;
    end else begin
      if (r < 10) begin
        v = '0;
      end else if (r < 20) begin
        v = r[0] ? NEG1 : 32'd1;
      end else if (r < 30) begin
        case ($urandom_range(3))
          0:       v = MIN32;
          1:       v = MAX32;
          2:       v = NEG1;
          default: v = 32'd1;
        endcase
      end else if (r < 60) begin
        v = VALUE_W'($urandom_range(2000)) - 32'd1000;
      end else if (r < 80) begin
        v = VALUE_W'($urandom_range(131071)) - 32'd65536;
      end else begin
        v = $urandom;
      end
    end
    return v;
  endfunction

  task automatic push_element(input logic [VALUE_W-1:0] v, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    fold_element(v, l);
  endtask

  task automatic check_product();
    product_t want;
    n_results++;
    if (m_tuser[0]) n_ovf_results++;
    if (pending_products.size() == 0) begin
      $error("unexpected result: product_except %0d", $signed(m_tdata));
      errors++;
    end else begin
      want = pending_products.pop_front();
      if (m_tdata !== want.product) begin
        $error("product_except: expected %0d, got %0d", $signed(want.product),
               $signed(m_tdata));
        errors++;
      end
      if (m_tuser[0] !== want.ovf) begin
        $error("overflow: expected %0b, got %0b", want.ovf, m_tuser[0]);
        errors++;
      end
      if (m_tlast !== want.last) begin
        $error("last_result: expected %0b, got %0b", want.last, m_tlast);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_product();
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_array_product_except_self NOT OK");
      $finish;
    end
  end

  initial begin
    int  sent;
    int  len;
    int  r;
    bit  tame;
    bit  open_end;
    clear_array();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      known_valid[held_count]   = DIRECTED[i].known;
      known_product[held_count] = DIRECTED[i].product;
      known_ovf[held_count]     = DIRECTED[i].ovf;
      push_element(DIRECTED[i].value, DIRECTED[i].last);
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = SRC_IDLE[p];
      sink_stall_pct = SINK_STALL[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        // open two phases with a full store
        if (sent == 0 && (p == 1 || p == 2)) len = DEPTH;
        else if (r < 85) len = $urandom_range(8, 1);
        else if (r < 96) len = $urandom_range(24, 9);
        else len = DEPTH;
        tame     = (len > 8) || ($urandom_range(3) == 0);
        open_end = (len == DEPTH) && ((sent == 0) ? (p == 1) : ($urandom_range(1) == 1));
        for (int i = 0; i < len; i++)
          push_element(draw_value(tame), (i == len - 1) && !open_end);
        sent += len;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d arrays (%0d elements) over four idle/stall mixes;",
             n_arrays, n_elements);
    $display("checked %0d products, %0d of them flagged as overflow.",
             n_results, n_ovf_results);
    if (errors == 0) $display("tb_array_product_except_self OK");
    else $display("tb_array_product_except_self NOT OK");
    $finish;
  end

endmodule

// ===== array_product_except_self.f =====
sv/apes_pkg.sv
sv/apes_store.sv
sv/apes_acc.sv
sv/apes_div.sv
sv/array_product_except_self.sv
sv/apes_checker.sv
bench/tb_array_product_except_self.sv
